>>> rtl/core/bctd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_pkg
// Shared types and constants of the byte class text detector: counter
// slots, byte class boundaries, register indexes and the config bundle.
// ----------------------------------------------------------------------------
package bctd_pkg;

  // counter slots
  localparam int NUM_CNT        = 9;
  localparam int CNT_TOTAL      = 0;
  localparam int CNT_CONTROL    = 1;
  localparam int CNT_SAFE_CTL   = 2;
  localparam int CNT_PRINTABLE  = 3;
  localparam int CNT_LEAD2      = 4;
  localparam int CNT_LEAD3      = 5;
  localparam int CNT_LEAD4      = 6;
  localparam int CNT_CONT       = 7;
  localparam int CNT_INVALID    = 8;

  // byte class boundaries
  localparam logic [7:0] BYTE_SPACE     = 8'h20;
  localparam logic [7:0] BYTE_TAB       = 8'h09;
  localparam logic [7:0] BYTE_LF        = 8'h0a;
  localparam logic [7:0] BYTE_FF        = 8'h0c;
  localparam logic [7:0] BYTE_CR        = 8'h0d;
  localparam logic [7:0] BYTE_ESC       = 8'h1b;
  localparam logic [7:0] BYTE_HIGH      = 8'h80;
  localparam logic [7:0] BYTE_LEAD2     = 8'hc0;
  localparam logic [7:0] BYTE_LEAD3     = 8'he0;
  localparam logic [7:0] BYTE_LEAD4     = 8'hf0;
  localparam logic [7:0] BYTE_INVALID   = 8'hf8;

  // percent scale
  localparam logic [6:0] PCT_SCALE      = 7'd100;

  // register indexes and reset values
  localparam logic [1:0] CFG_CONTROL_LIMIT = 2'd0;
  localparam logic [1:0] CFG_ASCII_MIN     = 2'd1;
  localparam logic [1:0] CFG_CONT_SLACK    = 2'd2;
  localparam logic [6:0] CONTROL_LIMIT_RST = 7'd2;
  localparam logic [6:0] ASCII_MIN_RST     = 7'd90;
  localparam logic [7:0] CONT_SLACK_RST    = 8'd3;

  typedef struct packed {
    logic [6:0] control_limit_percent;
    logic [6:0] ascii_min_percent;
    logic [7:0] continuation_slack;
  } cfg_t;

endpackage

>>> rtl/core/byte_class_text_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_class_text_detector
// Counts bytes by class with saturating counters and reports ASCII and
// UTF-8 verdicts plus class counts after a byte flagged as last.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  in_      | in_valid/in_stall  | data_byte, clear_before, last_byte
//  out_     | out_valid/out_stall| verdicts and four 32-bit counts
//  cfg_     | cfg_valid/cfg_ready| cfg_index (2b), cfg_data (8b)
//
// One byte per cycle while in_stall is low; counters update in the transfer cycle.
// A result passes from its last byte through the snapshot, sum and product
// registers to the result register, which the compare stage writes.
// Synchronous active-low reset clears counters and stage valids and loads the config reset values.
// in_stall rises only when all report stages hold results behind a
// stalled output; config writes are always ready.
// ----------------------------------------------------------------------------
module byte_class_text_detector #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_clear_before,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_mostly_ascii,
  output logic        out_looks_utf8,
  output logic [31:0] out_byte_total,
  output logic [31:0] out_unsafe_control_count,
  output logic [31:0] out_safe_ascii_count,
  output logic [31:0] out_eight_bit_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import bctd_pkg::*;

  cfg_t cfg_r;
  logic in_acc;
  logic [NUM_CNT-1:0][COUNT_BITS-1:0] cnt_nxt;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control_limit_percent <= CONTROL_LIMIT_RST;
      cfg_r.ascii_min_percent     <= ASCII_MIN_RST;
      cfg_r.continuation_slack    <= CONT_SLACK_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CONTROL_LIMIT: cfg_r.control_limit_percent <= cfg_data[6:0];
        CFG_ASCII_MIN:     cfg_r.ascii_min_percent     <= cfg_data[6:0];
        CFG_CONT_SLACK:    cfg_r.continuation_slack    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // class counters
  bctd_counters #(
    .CB (COUNT_BITS)
  ) u_counters (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .data_byte    (in_data_byte),
    .clear_before (in_clear_before),
    .cnt_nxt      (cnt_nxt)
  );

  // verdict pipeline
  bctd_report #(
    .CB (COUNT_BITS)
  ) u_report (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .in_acc                   (in_acc),
    .in_last                  (in_last_byte),
    .cnt_nxt                  (cnt_nxt),
    .cfg                      (cfg_r),
    .in_stall                 (in_stall),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_mostly_ascii         (out_mostly_ascii),
    .out_looks_utf8           (out_looks_utf8),
    .out_byte_total           (out_byte_total),
    .out_unsafe_control_count (out_unsafe_control_count),
    .out_safe_ascii_count     (out_safe_ascii_count),
    .out_eight_bit_count      (out_eight_bit_count)
  );

endmodule

>>> rtl/core/bctd_counters.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_counters
// Byte class decode and the saturating class counters. Exposes the
// next counter values so the report path can snapshot them on a last byte.
// ----------------------------------------------------------------------------
module bctd_counters #(
  parameter int CB = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                acc,
  input  logic [7:0]                          data_byte,
  input  logic                                clear_before,
  output logic [bctd_pkg::NUM_CNT-1:0][CB-1:0] cnt_nxt
);
  import bctd_pkg::*;

  logic [NUM_CNT-1:0][CB-1:0] cnt_r;
  logic [NUM_CNT-1:0]         bump_mask;

  // which counters a byte bumps
  function automatic logic [NUM_CNT-1:0] class_mask(input logic [7:0] b);
    logic [NUM_CNT-1:0] m;
    m = '0;
    m[CNT_TOTAL] = 1'b1;
    priority if (b < BYTE_SPACE) begin
      m[CNT_CONTROL] = 1'b1;
      if (b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR || b == BYTE_FF ||
          b == BYTE_ESC) begin
        m[CNT_SAFE_CTL] = 1'b1;
      end
    end else if (b < BYTE_HIGH) begin
      m[CNT_PRINTABLE] = 1'b1;
    end else if (b < BYTE_LEAD2) begin
      m[CNT_CONT] = 1'b1;
    end else if (b < BYTE_LEAD3) begin
      m[CNT_LEAD2] = 1'b1;
    end else if (b < BYTE_LEAD4) begin
      m[CNT_LEAD3] = 1'b1;
    end else if (b < BYTE_INVALID) begin
      m[CNT_LEAD4] = 1'b1;
    end else begin
      m[CNT_INVALID] = 1'b1;
    end
    return m;
  endfunction

  assign bump_mask = class_mask(data_byte);

  // clear then saturating increment on each transfer
  always_comb begin
    logic [CB-1:0] base;
    for (int i = 0; i < NUM_CNT; i++) begin
      base = clear_before ? '0 : cnt_r[i];
      cnt_nxt[i] = cnt_r[i];
      if (acc) begin
        cnt_nxt[i] = (bump_mask[i] && base != '1) ? base + CB'(1) : base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/bctd_report.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_report
// Verdict pipeline: snapshot, derived sums, percent products, compare and
// result register. Stages collapse bubbles so a waiting result never
// blocks new bytes while earlier stages are empty.
// ----------------------------------------------------------------------------
module bctd_report #(
  parameter int CB = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_acc,
  input  logic                                 in_last,
  input  logic [bctd_pkg::NUM_CNT-1:0][CB-1:0] cnt_nxt,
  input  bctd_pkg::cfg_t                       cfg,
  output logic                                 in_stall,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_mostly_ascii,
  output logic                                 out_looks_utf8,
  output logic [31:0]                          out_byte_total,
  output logic [31:0]                          out_unsafe_control_count,
  output logic [31:0]                          out_safe_ascii_count,
  output logic [31:0]                          out_eight_bit_count
);
  import bctd_pkg::*;

  localparam int DW = CB + 3;
  localparam int EW = (CB + 3 > 33) ? CB + 3 : 33;
  localparam int PW = CB + 9;

  function automatic logic [31:0] clamp32(input logic [EW-1:0] v);
    return (|v[EW-1:32]) ? 32'hffff_ffff : v[31:0];
  endfunction

  // stage flow control
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic ld1, ld2, ld3, ld4;

  assign ld4      = !out_valid_r || !out_stall;
  assign ld3      = !v3_r || ld4;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_stall = !ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_acc && in_last;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) out_valid_r <= v3_r;
    end
  end

  // stage 1: counter snapshot
  logic [NUM_CNT-1:0][CB-1:0] snap_r;

  always_ff @(posedge clk) begin
    if (ld1 && in_acc && in_last) snap_r <= cnt_nxt;
  end

  // stage 2: derived sums
  logic [CB-1:0] unsafe_c;
  logic [CB:0]   safe_c;
  logic [DW-1:0] eight_c, expected_c;
  logic [CB+1:0] utf8_c;

  always_comb begin
    unsafe_c = (snap_r[CNT_CONTROL] >= snap_r[CNT_SAFE_CTL]) ?
               snap_r[CNT_CONTROL] - snap_r[CNT_SAFE_CTL] : '0;
    safe_c   = (CB+1)'(snap_r[CNT_PRINTABLE]) + (CB+1)'(snap_r[CNT_SAFE_CTL]);
    eight_c  = DW'(snap_r[CNT_LEAD2]) + DW'(snap_r[CNT_LEAD3]) + DW'(snap_r[CNT_LEAD4])
               + DW'(snap_r[CNT_CONT]) + DW'(snap_r[CNT_INVALID]);
    utf8_c   = (CB+2)'(snap_r[CNT_PRINTABLE]) + (CB+2)'(snap_r[CNT_LEAD2])
               + (CB+2)'(snap_r[CNT_LEAD3]) + (CB+2)'(snap_r[CNT_LEAD4]);
    expected_c = DW'(snap_r[CNT_LEAD2]) + (DW'(snap_r[CNT_LEAD3]) << 1)
                 + DW'(snap_r[CNT_LEAD4]) + (DW'(snap_r[CNT_LEAD4]) << 1);
  end

  logic [CB-1:0] s2_total_r, s2_unsafe_r, s2_cont_r;
  logic [CB:0]   s2_safe_r;
  logic [DW-1:0] s2_eight_r, s2_expected_r;
  logic [CB+1:0] s2_utf8_r;
  logic          s2_inv_zero_r;

  always_ff @(posedge clk) begin
    if (ld2 && v1_r) begin
      s2_total_r    <= snap_r[CNT_TOTAL];
      s2_unsafe_r   <= unsafe_c;
      s2_cont_r     <= snap_r[CNT_CONT];
      s2_safe_r     <= safe_c;
      s2_eight_r    <= eight_c;
      s2_expected_r <= expected_c;
      s2_utf8_r     <= utf8_c;
      s2_inv_zero_r <= (snap_r[CNT_INVALID] == '0);
    end
  end

  // stage 3: percent products and continuation checks
  logic [PW-1:0] s3_unsafe_p_r, s3_tot_ctl_p_r, s3_safe_p_r, s3_tot_ascii_p_r;
  logic [PW-1:0] s3_utf8_ctl_p_r;
  logic          s3_total_nz_r, s3_utf8_nz_r, s3_cont_le_r, s3_slack_ok_r;
  logic          s3_inv_zero_r;
  logic [31:0]   s3_total_r, s3_unsafe_r, s3_safe_r, s3_eight_r;

  always_ff @(posedge clk) begin
    if (ld3 && v2_r) begin
      s3_unsafe_p_r    <= PW'(s2_unsafe_r) * PW'(PCT_SCALE);
      s3_tot_ctl_p_r   <= PW'(s2_total_r) * PW'(cfg.control_limit_percent);
      s3_safe_p_r      <= PW'(s2_safe_r) * PW'(PCT_SCALE);
      s3_tot_ascii_p_r <= PW'(s2_total_r) * PW'(cfg.ascii_min_percent);
      s3_utf8_ctl_p_r  <= PW'(s2_utf8_r) * PW'(cfg.control_limit_percent);
      s3_total_nz_r    <= (s2_total_r != '0);
      s3_utf8_nz_r     <= (s2_utf8_r != '0);
      s3_cont_le_r     <= (DW'(s2_cont_r) <= s2_expected_r);
      s3_slack_ok_r    <= (EW'(s2_cont_r) + EW'(cfg.continuation_slack))
                          >= EW'(s2_expected_r);
      s3_inv_zero_r    <= s2_inv_zero_r;
      s3_total_r       <= clamp32(EW'(s2_total_r));
      s3_unsafe_r      <= clamp32(EW'(s2_unsafe_r));
      s3_safe_r        <= clamp32(EW'(s2_safe_r));
      s3_eight_r       <= clamp32(EW'(s2_eight_r));
    end
  end

  // stage 4: verdict compares into the result register
  always_ff @(posedge clk) begin
    if (ld4 && v3_r) begin
      out_mostly_ascii <= s3_total_nz_r && (s3_unsafe_p_r < s3_tot_ctl_p_r)
                          && (s3_safe_p_r > s3_tot_ascii_p_r);
      out_looks_utf8   <= s3_utf8_nz_r && s3_cont_le_r && s3_slack_ok_r
                          && s3_inv_zero_r && (s3_unsafe_p_r < s3_utf8_ctl_p_r);
      out_byte_total           <= s3_total_r;
      out_unsafe_control_count <= s3_unsafe_r;
      out_safe_ascii_count     <= s3_safe_r;
      out_eight_bit_count      <= s3_eight_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // a last-byte transfer always lands in the snapshot stage
  a_last_snap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last) |=> v1_r)
    else $error("last byte transfer lost before snapshot");

  // no result appears without one in the product stage
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !v3_r) |=> !out_valid_r)
    else $error("result appeared without a pending report");

  // safe controls never outnumber controls in a snapshot
  a_safe_le_ctl: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (snap_r[CNT_SAFE_CTL] <= snap_r[CNT_CONTROL]))
    else $error("safe control count exceeds control count");

  // mostly-ascii verdict needs at least one byte
  a_ascii_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_mostly_ascii) |-> (out_byte_total != 32'd0))
    else $error("mostly ascii verdict with empty total");
`endif

endmodule
